/* src/pma_pkg.sv */
// shared types and constants for the pcm mix accumulate normalize block
`timescale 1ns / 1ps
`default_nettype none

package pma_pkg;

  localparam int FRAME_SAMPLES = 1024;
  localparam int ADDR_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 10;
  localparam int SMP_W  = 16;
  localparam int ACC_W  = 32;
  localparam int OUT_W  = 16;
  localparam int CNT_W  = 32;
  localparam int PEAK_W = 31;

  localparam logic [CMD_W-1:0] CMD_MIX_S16 = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MIX_S8  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MIX_U8  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DRAIN   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [ACC_W-1:0]  U8_BIAS   = 32'd128;
  localparam logic [OUT_W-1:0]  CLAMP_MAX = 16'h7fff;
  localparam logic [OUT_W-1:0]  CLAMP_MIN = 16'h8000;
  localparam logic [PEAK_W-1:0] PEAK_MAX  = 31'h7fff_ffff;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 32'hffff_ffff;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_MIX,
    OP_DRAIN,
    OP_CLEAR
  } pma_op_t;

  typedef struct packed {
    pma_op_t            op;
    logic [ADDR_W-1:0]  addr;
    logic [ACC_W-1:0]   addend;
  } pma_item_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } pma_bk_state_t;

  typedef struct packed {
    logic clearing;
    logic executing;
  } pma_bk_stat_t;

endpackage

`default_nettype wire

/* src/pma_front.sv */
// front end: takes commands, drops ignored ones and decodes sample addends
`timescale 1ns / 1ps
`default_nettype none

module pma_front (
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire logic [pma_pkg::CMD_W-1:0] in_command,
  input  wire logic [pma_pkg::POS_W-1:0] in_position,
  input  wire logic [pma_pkg::SMP_W-1:0] in_sample_in,
  output logic                           push,
  output pma_pkg::pma_item_t             item
);
  import pma_pkg::*;

  logic accept;
  logic in_range;
  logic known_cmd;

  assign accept   = start && !busy;
  assign in_range = (32'(in_position) < FRAME_SAMPLES);

  always_comb begin
    item.op     = OP_MIX;
    item.addr   = ADDR_W'(in_position);
    item.addend = '0;
    known_cmd   = 1'b1;
    case (in_command)
      CMD_MIX_S16: begin
        item.addend = {{(ACC_W-SMP_W){in_sample_in[SMP_W-1]}}, in_sample_in};
      end
      CMD_MIX_S8: begin
        item.addend = {{(ACC_W-8){in_sample_in[7]}}, in_sample_in[7:0]};
      end
      CMD_MIX_U8: begin
        // unsigned 8-bit is re-centered around zero
        item.addend = {{(ACC_W-8){1'b0}}, in_sample_in[7:0]} - U8_BIAS;
      end
      CMD_DRAIN: begin
        item.op = OP_DRAIN;
      end
      CMD_CLEAR: begin
        item.op = OP_CLEAR;
      end
      default: begin
        known_cmd = 1'b0;
      end
    endcase
  end

  assign push = accept && known_cmd && in_range;

endmodule

`default_nettype wire

/* src/pma_queue.sv */
// short command queue between the front end and the accumulator engine
`timescale 1ns / 1ps
`default_nettype none

module pma_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire pma_pkg::pma_item_t push_item,
  input  wire logic               pop,
  output logic                    not_empty,
  output logic                    full,
  output pma_pkg::pma_item_t      head
);
  import pma_pkg::*;

  pma_item_t           entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* src/pma_back.sv */
// accumulator engine: frame memory, read-modify-write, clamp and running stats
`timescale 1ns / 1ps
`default_nettype none

module pma_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  wire pma_pkg::pma_item_t         q_item,
  output logic                            q_pop,
  output pma_pkg::pma_bk_stat_t           stat,
  output logic                            out_valid,
  output logic signed [pma_pkg::OUT_W-1:0] out_mixed_sample,
  output logic                            out_clipped,
  output logic [pma_pkg::CNT_W-1:0]       out_clip_count,
  output logic [pma_pkg::PEAK_W-1:0]      out_peak
);
  import pma_pkg::*;

  pma_bk_state_t      state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  pma_item_t          item_r;

  logic [ACC_W-1:0]   mem [FRAME_SAMPLES];
  logic [ACC_W-1:0]   rd_data_r;
  logic               rd_en;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ACC_W-1:0]   wr_data;

  logic [PEAK_W-1:0]  peak_r, peak_nxt;
  logic [CNT_W-1:0]   clip_cnt_r, clip_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_smp_r, out_smp_nxt;
  logic               out_clip_r, out_clip_nxt;

  logic               clr_last;
  logic               acc_neg;
  logic [ACC_W-1:0]   mag_full;
  logic [PEAK_W-1:0]  mag;
  logic               clip_hi, clip_lo;

  assign clr_last = (clr_cnt_r == ADDR_W'(FRAME_SAMPLES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_last) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid) state_nxt = BK_EXEC;
      end
      BK_EXEC: begin
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_CLEAR;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    stat.clearing  = 1'b0;
    stat.executing = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        stat.clearing = 1'b1;
      end
      BK_IDLE: begin
        q_pop = q_valid;
        rd_en = q_valid;
      end
      BK_EXEC: begin
        stat.executing = 1'b1;
      end
      default: begin
        stat.clearing = 1'b1;
      end
    endcase
  end

  assign clr_cnt_nxt = stat.clearing ? clr_cnt_r + 1'b1 : clr_cnt_r;

  // drain arithmetic on the registered read data
  always_comb begin
    acc_neg  = rd_data_r[ACC_W-1];
    mag_full = acc_neg ? (~rd_data_r + 1'b1) : rd_data_r;
    // only the most negative value keeps the top bit after negation
    mag      = mag_full[ACC_W-1] ? PEAK_MAX : mag_full[PEAK_W-1:0];
    clip_hi  = !acc_neg && (|rd_data_r[ACC_W-2:OUT_W-1]);
    clip_lo  = acc_neg && !(&rd_data_r[ACC_W-2:OUT_W-1]);
  end

  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = item_r.addr;
    wr_data       = '0;
    peak_nxt      = peak_r;
    clip_cnt_nxt  = clip_cnt_r;
    out_valid_nxt = 1'b0;
    out_smp_nxt   = out_smp_r;
    out_clip_nxt  = out_clip_r;
    if (stat.clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
    end else if (stat.executing) begin
      case (item_r.op)
        OP_MIX: begin
          wr_en   = 1'b1;
          wr_data = rd_data_r + item_r.addend;
        end
        OP_CLEAR: begin
          wr_en = 1'b1;
        end
        OP_DRAIN: begin
          out_valid_nxt = 1'b1;
          if (mag > peak_r) peak_nxt = mag;
          out_clip_nxt = clip_hi || clip_lo;
          if (clip_hi) begin
            out_smp_nxt = CLAMP_MAX;
          end else if (clip_lo) begin
            out_smp_nxt = CLAMP_MIN;
          end else begin
            out_smp_nxt = rd_data_r[OUT_W-1:0];
          end
          if ((clip_hi || clip_lo) && (clip_cnt_r != COUNT_MAX)) begin
            clip_cnt_nxt = clip_cnt_r + 1'b1;
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      peak_r      <= '0;
      clip_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      peak_r      <= peak_nxt;
      clip_cnt_r  <= clip_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_smp_r  <= out_smp_nxt;
    out_clip_r <= out_clip_nxt;
    if (q_pop) begin
      item_r <= q_item;
    end
  end

  // accumulator memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[q_item.addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mixed_sample = out_smp_r;
  assign out_clipped      = out_clip_r;
  assign out_clip_count   = clip_cnt_r;
  assign out_peak         = peak_r;

  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> peak_r >= $past(peak_r))
    else $error("peak level decreased");

  a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == BK_EXEC) && ($past(item_r.op) == OP_DRAIN))
    else $error("result strobe without a drain being executed");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CLEAR) |-> !q_pop && !out_valid_nxt)
    else $error("command taken during the clearing pass");

  a_clip_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_clip_r |-> clip_cnt_r == $past(clip_cnt_r))
    else $error("clip total moved on an unclipped sample");

endmodule

`default_nettype wire

/* src/pcm_mix_accumulate_normalize.sv */
// top level of the pcm frame mixer with saturating 16-bit drain
//
// command port: a transaction is taken at a rising edge with start high and
// busy low. in_command selects mix s16 / mix s8 / mix u8 / drain / clear for
// the accumulator at in_position; unknown codes and positions outside the
// frame are dropped without effect.
// result port: only a drain produces a result. out_valid is high for exactly
// one cycle with the clamped sample, clip flag, clip total and peak.
// with the queue empty, a taken drain passes the queue entry, the registered
// accumulator read and the out_valid register before the result appears.
// throughput: the engine handles one command at a time (registered read of the
// single accumulator memory, then the write back); the front takes one
// command per cycle while the 2-entry queue has room, busy is high when full.
// reset: the accumulator frame is zeroed by a clearing pass over its
// FRAME_SAMPLES (1024) entries, during which busy is high. the receiver
// cannot stall, so results are never held back.
`timescale 1ns / 1ps
`default_nettype none

module pcm_mix_accumulate_normalize (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [pma_pkg::CMD_W-1:0]   in_command,
  input  wire logic [pma_pkg::POS_W-1:0]   in_position,
  input  wire logic signed [pma_pkg::SMP_W-1:0] in_sample_in,
  output logic                             out_valid,
  output logic signed [pma_pkg::OUT_W-1:0] out_mixed_sample,
  output logic                             out_clipped,
  output logic [pma_pkg::CNT_W-1:0]        out_clip_count,
  output logic [pma_pkg::PEAK_W-1:0]       out_peak
);
  import pma_pkg::*;

  logic         push;
  pma_item_t    push_item;
  logic         q_pop;
  logic         q_valid;
  logic         q_full;
  pma_item_t    q_head;
  pma_bk_stat_t bk_stat;

  assign busy = q_full || bk_stat.clearing;

  pma_front u_front (
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_position  (in_position),
    .in_sample_in (in_sample_in),
    .push         (push),
    .item         (push_item)
  );

  pma_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .not_empty (q_valid),
    .full      (q_full),
    .head      (q_head)
  );

  pma_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_head),
    .q_pop            (q_pop),
    .stat             (bk_stat),
    .out_valid        (out_valid),
    .out_mixed_sample (out_mixed_sample),
    .out_clipped      (out_clipped),
    .out_clip_count   (out_clip_count),
    .out_peak         (out_peak)
  );

endmodule

`default_nettype wire

/* dv/pcm_mix_accumulate_normalize_test.sv */
// self-checking testbench for the pcm frame mixer: directed table and random traffic
`timescale 1ns / 1ps

module pcm_mix_accumulate_normalize_test;
  import pma_pkg::*;

  // codes the block must drop without effect
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_WAIT    = 1000;

  typedef struct {
    logic signed [OUT_W-1:0] mixed;
    logic                    clipped;
    logic [CNT_W-1:0]        clip_count;
    logic [PEAK_W-1:0]       peak;
  } drain_result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [SMP_W-1:0] smp;
    bit               typed;
    drain_result_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [CMD_W-1:0] in_command = '0;
  logic [POS_W-1:0] in_position = '0;
  logic signed [SMP_W-1:0] in_sample_in = '0;
  logic busy;
  logic out_valid;
  logic signed [OUT_W-1:0] out_mixed_sample;
  logic out_clipped;
  logic [CNT_W-1:0] out_clip_count;
  logic [PEAK_W-1:0] out_peak;

  always #5 clk = ~clk;

  pcm_mix_accumulate_normalize dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_sample_in     (in_sample_in),
    .out_valid        (out_valid),
    .out_mixed_sample (out_mixed_sample),
    .out_clipped      (out_clipped),
    .out_clip_count   (out_clip_count),
    .out_peak         (out_peak)
  );

  // mirror of the block's state
  logic [ACC_W-1:0]  frame_acc [FRAME_SAMPLES];
  logic [CNT_W-1:0]  clip_total_m;
  logic [PEAK_W-1:0] peak_m;

  drain_result_t drains_due[$];
  stim_row_t directed[23];
  drain_result_t no_result;
  int errors = 0;
  int accepted = 0;
  int drains_seen = 0;
  int clips_seen = 0;

  task automatic report_mismatch(input string msg);
    begin
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    end
  endtask

  function automatic logic [ACC_W-1:0] addend_for(input logic [CMD_W-1:0] cmd,
                                                  input logic [SMP_W-1:0] smp);
    case (cmd)
      CMD_MIX_S16: return {{(ACC_W-SMP_W){smp[SMP_W-1]}}, smp};
      CMD_MIX_S8:  return {{(ACC_W-8){smp[7]}}, smp[7:0]};
      default:     return {{(ACC_W-8){1'b0}}, smp[7:0]} - U8_BIAS;
    endcase
  endfunction

  // applies one command to the mirror; returns 1 when it yields a drain result
  function automatic bit mix_frame_update(input logic [CMD_W-1:0] cmd,
                                          input logic [POS_W-1:0] pos,
                                          input logic [SMP_W-1:0] smp,
                                          output drain_result_t r);
    longint val;
    longint mag;
    r = '{mixed: '0, clipped: 1'b0, clip_count: '0, peak: '0};
    if (int'(pos) >= FRAME_SAMPLES) return 0;
    case (cmd)
      CMD_MIX_S16, CMD_MIX_S8, CMD_MIX_U8: begin
        frame_acc[pos] = frame_acc[pos] + addend_for(cmd, smp);
        return 0;
      end
      CMD_CLEAR: begin
        frame_acc[pos] = '0;
        return 0;
      end
      CMD_DRAIN: begin
        val = longint'($signed(frame_acc[pos]));
        mag = (val < 0) ? -val : val;
        if (mag > longint'(PEAK_MAX)) mag = longint'(PEAK_MAX);
        if (mag > longint'(peak_m)) peak_m = mag[PEAK_W-1:0];
        if (val > longint'($signed(CLAMP_MAX))) begin
          r.mixed = CLAMP_MAX;
          r.clipped = 1'b1;
        end else if (val < longint'($signed(CLAMP_MIN))) begin
          r.mixed = CLAMP_MIN;
          r.clipped = 1'b1;
        end else begin
          r.mixed = frame_acc[pos][OUT_W-1:0];
        end
        if (r.clipped && clip_total_m != COUNT_MAX) clip_total_m = clip_total_m + 1'b1;
        r.clip_count = clip_total_m;
        r.peak = peak_m;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic stim_row_t mk(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                   input logic [SMP_W-1:0] smp, input bit typed,
                                   input logic [OUT_W-1:0] mixed, input logic clipped,
                                   input logic [CNT_W-1:0] cnt, input logic [PEAK_W-1:0] pk);
    stim_row_t row;
    row.cmd = cmd;
    row.pos = pos;
    row.smp = smp;
    row.typed = typed;
    row.want = '{mixed: mixed, clipped: clipped, clip_count: cnt, peak: pk};
    return row;
  endfunction

  // drives one transaction and waits for the edge that takes it
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                       input logic [SMP_W-1:0] smp, input bit typed,
                       input drain_result_t want);
    drain_result_t r;
    begin
      start <= 1'b1;
      in_command <= cmd;
      in_position <= pos;
      in_sample_in <= smp;
      @(posedge clk);
      while (busy !== 1'b0) @(posedge clk);
      accepted++;
      if (mix_frame_update(cmd, pos, smp, r)) begin
        if (typed) drains_due.push_back(want);
        else drains_due.push_back(r);
      end
    end
  endtask

  task automatic idle(input int cycles);
    begin
      start <= 1'b0;
      in_command <= CMD_W'($urandom);
      in_position <= POS_W'($urandom);
      in_sample_in <= SMP_W'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic settle_all();
    begin
      start <= 1'b0;
      @(posedge clk);
      while (drains_due.size() != 0) @(posedge clk);
    end
  endtask

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: begin
        case ($urandom_range(0, 5))
          0: return 16'hffff;
          1: return 16'h0000;
          2: return 16'h0001;
          3: return 16'h007f;
          4: return 16'h0080;
          default: return 16'h00ff;
        endcase
      end
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    // a small hot window lets mixes pile up before they are drained
    if (r < 70) return POS_W'($urandom_range(0, 15));
    if (r < 80) return POS_W'(FRAME_SAMPLES - 1 - $urandom_range(0, 3));
    return POS_W'($urandom_range(0, FRAME_SAMPLES - 1));
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CMD_MIX_S16;
    if (r < 42) return CMD_MIX_S8;
    if (r < 54) return CMD_MIX_U8;
    if (r < 80) return CMD_DRAIN;
    if (r < 88) return CMD_CLEAR;
    return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
  endfunction

  always @(posedge clk) begin
    drain_result_t w;
    if (out_valid === 1'b1) begin
      drains_seen++;
      if (out_clipped === 1'b1) clips_seen++;
      if (drains_due.size() == 0) begin
        report_mismatch($sformatf("result with no drain pending, sample %0d", out_mixed_sample));
      end else begin
        w = drains_due.pop_front();
        if (out_mixed_sample !== w.mixed)
          report_mismatch($sformatf("drain %0d mixed_sample got %0d expected %0d",
                                    drains_seen, out_mixed_sample, w.mixed));
        if (out_clipped !== w.clipped)
          report_mismatch($sformatf("drain %0d clipped got %0b expected %0b",
                                    drains_seen, out_clipped, w.clipped));
        if (out_clip_count !== w.clip_count)
          report_mismatch($sformatf("drain %0d clip_count got %0d expected %0d",
                                    drains_seen, out_clip_count, w.clip_count));
        if (out_peak !== w.peak)
          report_mismatch($sformatf("drain %0d peak got %0d expected %0d",
                                    drains_seen, out_peak, w.peak));
      end
    end
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int effective;
    int waited;
    bit quiet;
    logic [CMD_W-1:0] cmd;
    foreach (frame_acc[i]) frame_acc[i] = '0;
    clip_total_m = '0;
    peak_m = '0;
    no_result = '{mixed: '0, clipped: 1'b0, clip_count: '0, peak: '0};

    directed[0]  = mk(CMD_DRAIN,   10'd0,    16'h0000, 1, 16'h0000, 0, 0, 0);
    directed[1]  = mk(CMD_DRAIN,   10'd1023, 16'hffff, 1, 16'h0000, 0, 0, 0);
    directed[2]  = mk(CMD_MIX_S16, 10'd0,    16'h7fff, 0, 0, 0, 0, 0);
    directed[3]  = mk(CMD_DRAIN,   10'd0,    16'h0000, 1, 16'h7fff, 0, 0, 32767);
    directed[4]  = mk(CMD_MIX_S16, 10'd0,    16'h0001, 0, 0, 0, 0, 0);
    directed[5]  = mk(CMD_DRAIN,   10'd0,    16'h0000, 1, 16'h7fff, 1, 1, 32768);
    directed[6]  = mk(CMD_MIX_S16, 10'd1023, 16'h8000, 0, 0, 0, 0, 0);
    directed[7]  = mk(CMD_DRAIN,   10'd1023, 16'h0000, 1, 16'h8000, 0, 1, 32768);
    directed[8]  = mk(CMD_MIX_S16, 10'd1023, 16'hffff, 0, 0, 0, 0, 0);
    directed[9]  = mk(CMD_DRAIN,   10'd1023, 16'h0000, 1, 16'h8000, 1, 2, 32769);
    directed[10] = mk(CMD_CLEAR,   10'd0,    16'h5a5a, 0, 0, 0, 0, 0);
    directed[11] = mk(CMD_DRAIN,   10'd0,    16'h0000, 1, 16'h0000, 0, 2, 32769);
    // 8-bit formats only look at the low byte
    directed[12] = mk(CMD_MIX_S8,  10'd2,    16'ha57f, 0, 0, 0, 0, 0);
    directed[13] = mk(CMD_MIX_S8,  10'd2,    16'h0080, 0, 0, 0, 0, 0);
    directed[14] = mk(CMD_MIX_U8,  10'd3,    16'hff00, 0, 0, 0, 0, 0);
    directed[15] = mk(CMD_MIX_U8,  10'd3,    16'h00ff, 0, 0, 0, 0, 0);
    directed[16] = mk(CMD_DRAIN,   10'd2,    16'h0000, 0, 0, 0, 0, 0);
    directed[17] = mk(CMD_DRAIN,   10'd3,    16'h0000, 0, 0, 0, 0, 0);
    directed[18] = mk(CMD_SPARE_FIRST, 10'd2, 16'h1234, 0, 0, 0, 0, 0);
    directed[19] = mk(CMD_SPARE_LAST,  10'd3, 16'h8000, 0, 0, 0, 0, 0);
    directed[20] = mk(CMD_DRAIN,   10'd2,    16'h0000, 0, 0, 0, 0, 0);
    directed[21] = mk(CMD_CLEAR,   10'd1023, 16'h0000, 0, 0, 0, 0, 0);
    directed[22] = mk(CMD_DRAIN,   10'd1023, 16'h0000, 1, 16'h0000, 0, 2, 32769);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      issue(directed[i].cmd, directed[i].pos, directed[i].smp, directed[i].typed,
            directed[i].want);

    // sender holds off until every drain has come back
    settle_all();

    effective = 0;
    while (effective < RANDOM_ITEMS) begin
      quiet = (effective >= 150 && effective < 300);
      if (!quiet && $urandom_range(0, 99) < 12) idle($urandom_range(1, 5));
      if (effective == 350) settle_all();
      cmd = pick_command();
      issue(cmd, pick_position(), pick_sample(), 0, no_result);
      if (cmd < CMD_SPARE_FIRST) effective++;
    end

    start <= 1'b0;
    waited = 0;
    while (drains_due.size() != 0 && waited < DRAIN_WAIT) begin
      @(posedge clk);
      waited++;
    end
    while (drains_due.size() != 0) begin
      void'(drains_due.pop_front());
      report_mismatch("expected drain result never arrived");
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d transactions: all mix formats, drain, clear and spare codes",
             accepted);
    $display("%0d drain results checked, %0d clipped, clamping at both rails included",
             drains_seen, clips_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/pma_pkg.sv
src/pma_front.sv
src/pma_queue.sv
src/pma_back.sv
src/pcm_mix_accumulate_normalize.sv
dv/pcm_mix_accumulate_normalize_test.sv
